// ===== sv/tlsf_pkg.sv =====
package tlsf_pkg;

  // Index geometry
  localparam int SUB_LOG    = 4;
  localparam int SUB_DIM    = 1 << SUB_LOG;
  localparam int LEVELS     = 28;
  localparam int COUNT_BITS = 16;
  localparam int FI_W       = $clog2(LEVELS);
  localparam int CNT_AW     = FI_W + SUB_LOG;
  localparam int CNT_DEPTH  = LEVELS * SUB_DIM;
  localparam int SIZE_W     = 32;
  localparam int LVL_W      = 6;   // holds levels 0..32 of a rounded 33-bit size
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 2'd1;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_TAKE   = 2'd3
  } op_e;

  // Ones from bit 0 up to the highest set bit
  function automatic logic [SIZE_W-1:0] smear(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] s;
    s = v;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s;
  endfunction

  // Position of the highest set bit of a rounded size
  function automatic logic [LVL_W-1:0] top_bit(input logic [SIZE_W:0] v);
    logic [LVL_W-1:0] n;
    n = '0;
    for (int i = 0; i <= SIZE_W; i++) begin
      if (v[i]) n = LVL_W'(i);
    end
    return n;
  endfunction

  function automatic logic [SUB_LOG-1:0] low_sub(input logic [SUB_DIM-1:0] v);
    logic [SUB_LOG-1:0] n;
    n = '0;
    for (int i = SUB_DIM - 1; i >= 0; i--) begin
      if (v[i]) n = SUB_LOG'(i);
    end
    return n;
  endfunction

  function automatic logic [FI_W-1:0] low_level(input logic [LEVELS-1:0] v);
    logic [FI_W-1:0] n;
    n = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (v[i]) n = FI_W'(i);
    end
    return n;
  endfunction

endpackage

// ===== sv/tlsf_free_list_index_engine_top.sv =====
// Two-level segregated-fit free-list index engine. A request (operation, chunk_size) is
// taken when start_i is high and busy_o is low; exactly one result follows, shown for a
// single cycle with done_o high, and it must be captured then since the engine never
// waits for the receiver. The next request may be given in the cycle the result shows.
// Requests are handled one at a time through a sequencer around two single-port memories
// (per-level sublist bitmaps and per-list counts, read data registered) plus a level
// bitmap in flops. Insert and remove go through the map step, a memory read and a
// read-modify-write; find rounds the size first and, when the search moves to a higher
// level, reads that level's bitmap; take then reads and updates the found list. No
// clearing pass after reset: a bitmap word counts only while its level bit is set and a
// count only while its sublist bit is set. The user must write configuration
// (cfg_index_i 0 min_level, 1 max_level) only while the engine is idle; not enforced.
module tlsf_free_list_index_engine_top
  import tlsf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           operation_i,
  input  logic [SIZE_W-1:0]    chunk_size_i,
  output logic                 done_o,
  output logic [FI_W-1:0]      first_level_o,
  output logic [SUB_LOG-1:0]   second_level_o,
  output logic [1:0]           status_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_MAP,
    ST_READ,
    ST_EXEC,
    ST_SUBRD,
    ST_SUBSEL
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]   min_level_q, max_level_q;
  op_e                op_q, op_d;
  logic [SIZE_W:0]    size_q, size_d;
  logic [FI_W-1:0]    fi_q, fi_d;
  logic [SUB_LOG-1:0] sl_q, sl_d;
  logic               take_rm_q, take_rm_d;
  logic [LEVELS-1:0]  level_bm_q, level_bm_d;
  logic               done_q, done_d;
  logic [FI_W-1:0]    res_fi_q, res_fi_d;
  logic [SUB_LOG-1:0] res_sl_q, res_sl_d;
  logic [1:0]         res_st_q, res_st_d;

  // Memories and their registered read data
  logic [SUB_DIM-1:0]    bmp_mem [LEVELS];
  logic [COUNT_BITS-1:0] cnt_mem [CNT_DEPTH];
  logic [SUB_DIM-1:0]    bmp_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic                  rd_en;
  logic                  bmp_we, cnt_we;
  logic [SUB_DIM-1:0]    bmp_wdata;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [CNT_AW-1:0]     cnt_addr;

  // Map step signals
  logic [LVL_W-1:0]   lvl;
  logic [LVL_W-1:0]   min_ext, max_ext;
  logic [LVL_W-1:0]   lvl_idx;
  logic               map_err;
  logic [SIZE_W:0]    sub_hi;
  logic [SUB_LOG-1:0] sub_lo;
  logic [SUB_LOG-1:0] map_sl;

  // Execute step signals
  logic [SUB_DIM-1:0]    bmp_eff, sl_bit, bmp_above, bmp_cleared;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [LEVELS-1:0]     lvl_above;
  logic                  search;

  assign search   = (operation_i == OP_FIND) || (operation_i == OP_TAKE);
  assign cnt_addr = {fi_q, sl_q};
  assign rd_en    = (state_q == ST_READ) || (state_q == ST_SUBRD);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_level_q <= CFG_W'(4);
      max_level_q <= CFG_W'(31);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MIN_LEVEL) min_level_q <= cfg_data_i;
      if (cfg_index_i == REG_MAX_LEVEL) max_level_q <= cfg_data_i;
    end
  end

  // Size to (level, sublist) mapping
  assign lvl     = top_bit(size_q);
  assign min_ext = LVL_W'(min_level_q);
  assign max_ext = LVL_W'(max_level_q);
  assign lvl_idx = lvl - min_ext;
  assign map_err = (size_q == '0) || (lvl > max_ext) || (lvl < min_ext) ||
                   (lvl_idx >= LVL_W'(LEVELS));
  assign sub_hi  = size_q >> (lvl - LVL_W'(SUB_LOG));
  assign sub_lo  = size_q[SUB_LOG-1:0] << (LVL_W'(SUB_LOG) - lvl);
  assign map_sl  = (lvl >= LVL_W'(SUB_LOG)) ? sub_hi[SUB_LOG-1:0] : sub_lo;

  // Stored words read back through their valid bits
  assign bmp_eff     = level_bm_q[fi_q] ? bmp_rd_q : '0;
  assign sl_bit      = SUB_DIM'(1) << sl_q;
  assign cnt_eff     = ((bmp_eff & sl_bit) != '0) ? cnt_rd_q : '0;
  assign bmp_above   = bmp_eff & ({SUB_DIM{1'b1}} << sl_q);
  assign bmp_cleared = (cnt_eff == COUNT_BITS'(1)) ? (bmp_eff & ~sl_bit) : bmp_eff;
  assign lvl_above   = level_bm_q & ({LEVELS{1'b1}} << (LVL_W'(fi_q) + LVL_W'(1)));

  // Sequencer next state
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    size_d     = size_q;
    fi_d       = fi_q;
    sl_d       = sl_q;
    take_rm_d  = take_rm_q;
    level_bm_d = level_bm_q;
    done_d     = 1'b0;
    res_fi_d   = res_fi_q;
    res_sl_d   = res_sl_q;
    res_st_d   = res_st_q;
    bmp_we     = 1'b0;
    cnt_we     = 1'b0;
    bmp_wdata  = bmp_eff;
    cnt_wdata  = cnt_eff;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d      = op_e'(operation_i);
          size_d    = {1'b0, chunk_size_i};
          take_rm_d = 1'b0;
          state_d   = search ? ST_ROUND : ST_MAP;
        end
      end

      // Round search sizes up to the next list boundary
      ST_ROUND: begin
        size_d  = size_q + {1'b0, smear(size_q[SIZE_W-1:0]) >> (SUB_LOG + 1)};
        state_d = ST_MAP;
      end

      ST_MAP: begin
        if (map_err) begin
          done_d   = 1'b1;
          res_fi_d = '0;
          res_sl_d = '0;
          res_st_d = STAT_RANGE;
          state_d  = ST_IDLE;
        end else begin
          fi_d    = lvl_idx[FI_W-1:0];
          sl_d    = map_sl;
          state_d = ST_READ;
        end
      end

      ST_READ: state_d = ST_EXEC;

      ST_EXEC: begin
        if (op_q == OP_INSERT) begin
          done_d   = 1'b1;
          res_fi_d = fi_q;
          res_sl_d = sl_q;
          state_d  = ST_IDLE;
          if (cnt_eff == COUNT_MAX) begin
            res_st_d = STAT_COUNT;
          end else begin
            res_st_d             = STAT_OK;
            cnt_we               = 1'b1;
            cnt_wdata            = cnt_eff + COUNT_BITS'(1);
            bmp_we               = 1'b1;
            bmp_wdata            = bmp_eff | sl_bit;
            level_bm_d[fi_q]     = 1'b1;
          end
        end else if (op_q == OP_REMOVE || take_rm_q) begin
          done_d   = 1'b1;
          res_fi_d = fi_q;
          res_sl_d = sl_q;
          state_d  = ST_IDLE;
          if (cnt_eff == '0) begin
            res_st_d = STAT_COUNT;
          end else begin
            res_st_d  = STAT_OK;
            cnt_we    = 1'b1;
            cnt_wdata = cnt_eff - COUNT_BITS'(1);
            bmp_we    = 1'b1;
            bmp_wdata = bmp_cleared;
            if (bmp_cleared == '0) level_bm_d[fi_q] = 1'b0;
          end
        end else if (bmp_above != '0) begin
          // Hit in the requested level
          sl_d = low_sub(bmp_above);
          if (op_q == OP_TAKE) begin
            take_rm_d = 1'b1;
            state_d   = ST_READ;
          end else begin
            done_d   = 1'b1;
            res_fi_d = fi_q;
            res_sl_d = low_sub(bmp_above);
            res_st_d = STAT_OK;
            state_d  = ST_IDLE;
          end
        end else if (lvl_above != '0) begin
          fi_d    = low_level(lvl_above);
          state_d = ST_SUBRD;
        end else begin
          done_d   = 1'b1;
          res_fi_d = '0;
          res_sl_d = '0;
          res_st_d = STAT_RANGE;
          state_d  = ST_IDLE;
        end
      end

      ST_SUBRD: state_d = ST_SUBSEL;

      // First list of the higher level; its level bit is set, so the word is live
      ST_SUBSEL: begin
        sl_d = low_sub(bmp_rd_q);
        if (op_q == OP_TAKE) begin
          take_rm_d = 1'b1;
          state_d   = ST_READ;
        end else begin
          done_d   = 1'b1;
          res_fi_d = fi_q;
          res_sl_d = low_sub(bmp_rd_q);
          res_st_d = STAT_OK;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_INSERT;
      size_q     <= '0;
      fi_q       <= '0;
      sl_q       <= '0;
      take_rm_q  <= 1'b0;
      level_bm_q <= '0;
      done_q     <= 1'b0;
      res_fi_q   <= '0;
      res_sl_q   <= '0;
      res_st_q   <= STAT_OK;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      size_q     <= size_d;
      fi_q       <= fi_d;
      sl_q       <= sl_d;
      take_rm_q  <= take_rm_d;
      level_bm_q <= level_bm_d;
      done_q     <= done_d;
      res_fi_q   <= res_fi_d;
      res_sl_q   <= res_sl_d;
      res_st_q   <= res_st_d;
    end
  end

  // Sublist bitmap memory
  always_ff @(posedge clk_i) begin
    if (bmp_we) bmp_mem[fi_q] <= bmp_wdata;
    if (rd_en) bmp_rd_q <= bmp_mem[fi_q];
  end

  // List count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
    if (rd_en) cnt_rd_q <= cnt_mem[cnt_addr];
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign first_level_o  = res_fi_q;
  assign second_level_o = res_sl_q;
  assign status_o       = res_st_q;

`ifndef SYNTHESIS
  // A result only shows once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  // An accepted request occupies the engine
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("request not taken up");

  // Range or no-fit results carry zero indices
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_RANGE) |-> (first_level_o == '0 && second_level_o == '0))
    else $error("out-of-range result with non-zero indices");

  // A successful find points at an occupied level
  a_find_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_OK && op_q == OP_FIND) |-> level_bm_q[first_level_o])
    else $error("find returned an empty level");
`endif

endmodule

// ===== dv/tb_tlsf_free_list_index_engine_top.sv =====
module tb_tlsf_free_list_index_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlsf_pkg::*;

  localparam int          CLK_HALF        = 10;
  localparam int          RESET_CYCLES    = 12;
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int          DRAIN_CYCLES    = 16;
  localparam int          PHASES          = 8;
  localparam int          ITEMS_PER_PHASE = 150;
  localparam int          HOT_LISTS       = 6;
  localparam int unsigned LEVEL_FLOOR     = 4;
  localparam int unsigned LEVEL_CEIL      = 31;

  localparam logic [CFG_W-1:0]     MIN_LEVEL_RESET = 5'd4;
  localparam logic [CFG_W-1:0]     MAX_LEVEL_RESET = 5'd31;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI    = 2'd3;

  // level 5, sublist 8: used for the closing insert/remove sequence
  localparam logic [SIZE_W-1:0]    FILL_SIZE       = 32'h30;

  typedef struct packed {
    logic [FI_W-1:0]    fi;
    logic [SUB_LOG-1:0] sl;
    logic [1:0]         status;
  } index_result_t;

  // Mirror of the free-list index state plus the queue of outstanding results
  class list_index_tracker;
    logic [LEVELS-1:0]     level_bits;
    logic [SUB_DIM-1:0]    sub_bits [LEVELS];
    logic [COUNT_BITS-1:0] counts [CNT_DEPTH];
    logic [CFG_W-1:0]      min_lvl;
    logic [CFG_W-1:0]      max_lvl;
    index_result_t         expected_indices [$];
    int unsigned           mismatches;

    function new();
      level_bits = '0;
      foreach (sub_bits[i]) sub_bits[i] = '0;
      foreach (counts[i]) counts[i] = '0;
      min_lvl    = MIN_LEVEL_RESET;
      max_lvl    = MAX_LEVEL_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_MIN_LEVEL: min_lvl = data;
        REG_MAX_LEVEL: max_lvl = data;
        default: ;
      endcase
    endfunction

    function int unsigned msb_pos(logic [SIZE_W:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i <= SIZE_W; i++) if (v[i]) n = i;
      return n;
    endfunction

    function int unsigned first_set(logic [63:0] v);
      for (int i = 0; i < 64; i++) if (v[i]) return i;
      return 0;
    endfunction

    // size -> (level index, sublist); search requests round up to the next list
    function bit map_size(logic [SIZE_W-1:0] size, bit search,
                          output logic [FI_W-1:0] fi, output logic [SUB_LOG-1:0] sl);
      logic [SIZE_W:0] sz;
      logic [SIZE_W:0] sub;
      int unsigned     lvl;
      sz = {1'b0, size};
      fi = '0;
      sl = '0;
      if (sz == '0) return 1'b0;
      lvl = msb_pos(sz);
      if (search && lvl >= SUB_LOG) sz = sz + ((33'd1 << (lvl - SUB_LOG)) - 33'd1);
      lvl = msb_pos(sz);
      if (lvl > max_lvl || lvl < min_lvl) return 1'b0;
      if (lvl - min_lvl >= LEVELS) return 1'b0;
      // small levels shift up so the leading one still drops out
      if (lvl >= SUB_LOG) sub = sz >> (lvl - SUB_LOG);
      else sub = sz << (SUB_LOG - lvl);
      sl = sub[SUB_LOG-1:0];
      fi = FI_W'(lvl - min_lvl);
      return 1'b1;
    endfunction

    function logic [1:0] remove_one(logic [FI_W-1:0] fi, logic [SUB_LOG-1:0] sl);
      int unsigned k;
      k = int'(fi) * SUB_DIM + int'(sl);
      if (counts[k] == '0) return STAT_COUNT;
      counts[k] = counts[k] - 1'b1;
      if (counts[k] == '0) begin
        sub_bits[fi][sl] = 1'b0;
        if (sub_bits[fi] == '0) level_bits[fi] = 1'b0;
      end
      return STAT_OK;
    endfunction

    // Update the mirror for one accepted request and queue its result
    function void note_request(op_e op, logic [SIZE_W-1:0] size);
      index_result_t      r;
      logic [FI_W-1:0]    fi;
      logic [SUB_LOG-1:0] sl;
      logic [SUB_DIM-1:0] sub_hits;
      logic [LEVELS-1:0]  lvl_hits;
      int unsigned        k;
      r.status = STAT_OK;
      if (!map_size(size, (op == OP_FIND || op == OP_TAKE), fi, sl)) begin
        fi       = '0;
        sl       = '0;
        r.status = STAT_RANGE;
      end else begin
        case (op)
          OP_INSERT: begin
            k = int'(fi) * SUB_DIM + int'(sl);
            if (counts[k] == COUNT_MAX) begin
              r.status = STAT_COUNT;
            end else begin
              counts[k]        = counts[k] + 1'b1;
              sub_bits[fi][sl] = 1'b1;
              level_bits[fi]   = 1'b1;
            end
          end
          OP_REMOVE: r.status = remove_one(fi, sl);
          default: begin
            // first non-empty list at or above the rounded one
            sub_hits = sub_bits[fi] & ({SUB_DIM{1'b1}} << sl);
            if (sub_hits != '0) begin
              sl = SUB_LOG'(first_set(64'(sub_hits)));
            end else begin
              lvl_hits = level_bits & ({LEVELS{1'b1}} << (int'(fi) + 1));
              if (lvl_hits == '0) begin
                fi       = '0;
                sl       = '0;
                r.status = STAT_RANGE;
              end else begin
                fi = FI_W'(first_set(64'(lvl_hits)));
                sl = SUB_LOG'(first_set(64'(sub_bits[fi])));
              end
            end
            if (r.status == STAT_OK && op == OP_TAKE) r.status = remove_one(fi, sl);
          end
        endcase
      end
      r.fi = fi;
      r.sl = sl;
      expected_indices.push_back(r);
    endfunction

    function void check_result(logic [FI_W-1:0] fi, logic [SUB_LOG-1:0] sl,
                               logic [1:0] status);
      index_result_t exp_r;
      if (expected_indices.size() == 0) begin
        $display("%0t: unexpected result first_level=%0d second_level=%0d status=%0d",
                 $time, fi, sl, status);
        mismatches++;
        return;
      end
      exp_r = expected_indices.pop_front();
      if (fi !== exp_r.fi) begin
        $display("%0t: first_level expected %0d actual %0d", $time, exp_r.fi, fi);
        mismatches++;
      end
      if (sl !== exp_r.sl) begin
        $display("%0t: second_level expected %0d actual %0d", $time, exp_r.sl, sl);
        mismatches++;
      end
      if (status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_indices.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 start_i;
  logic                 busy_o;
  logic [1:0]           operation_i;
  logic [SIZE_W-1:0]    chunk_size_i;
  logic                 done_o;
  logic [FI_W-1:0]      first_level_o;
  logic [SUB_LOG-1:0]   second_level_o;
  logic [1:0]           status_o;

  list_index_tracker tracker;
  int unsigned       cycles = 0;
  int unsigned       burst_left;
  int unsigned       hot_lvl [HOT_LISTS];
  int unsigned       hot_sub [HOT_LISTS];

  tlsf_free_list_index_engine_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .chunk_size_i   (chunk_size_i),
    .done_o         (done_o),
    .first_level_o  (first_level_o),
    .second_level_o (second_level_o),
    .status_o       (status_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[tlsf_free_list_index_engine_top] ERROR");
      $finish;
    end
  end

  // Result capture: each result is valid for one cycle only
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(first_level_o, second_level_o, status_o);
  end

  // Sender gap, with occasional back-to-back bursts
  function automatic int unsigned draw_gap();
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // A size in list (lvl, sub) with random bits below the sublist field
  function automatic logic [SIZE_W-1:0] size_in_list(int unsigned lvl, int unsigned sub);
    logic [SIZE_W:0] low_mask;
    logic [SIZE_W:0] s;
    low_mask = (33'd1 << (lvl - SUB_LOG)) - 33'd1;
    s = (33'd1 << lvl) | (33'(sub) << (lvl - SUB_LOG)) | (33'($urandom) & low_mask);
    return s[SIZE_W-1:0];
  endfunction

  // Register write, followed by an idle gap with the write enable low
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Present one request and hold it until the engine takes it
  task automatic issue(op_e op, logic [SIZE_W-1:0] size, int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    operation_i  <= op;
    chunk_size_i <= size;
    do @(posedge clk_i); while (busy_o);
    tracker.note_request(op, size);
  endtask

  task automatic wait_idle();
    while (tracker.pending() != 0 || busy_o) @(posedge clk_i);
  endtask

  // Edge sizes, every operation, rounding, empty search, underflow, small levels
  task automatic run_directed();
    issue(OP_INSERT, 32'h10, draw_gap());
    issue(OP_INSERT, 32'hFFFF_FFFF, draw_gap());
    issue(OP_FIND, 32'h10, draw_gap());
    issue(OP_FIND, 32'h11, draw_gap());
    issue(OP_TAKE, 32'h8000_0001, draw_gap());
    issue(OP_FIND, 32'hFFFF_FFFF, draw_gap());    // rounding overflows into bit 32
    issue(OP_REMOVE, 32'hFFFF_FFFF, draw_gap());  // underflow
    issue(OP_REMOVE, 32'h10, draw_gap());
    issue(OP_REMOVE, 32'h10, draw_gap());
    issue(OP_FIND, 32'h10, draw_gap());           // nothing left
    issue(OP_TAKE, 32'h20, draw_gap());
    issue(OP_INSERT, 32'h0, draw_gap());
    issue(OP_INSERT, 32'h1, draw_gap());
    issue(OP_INSERT, 32'hF, draw_gap());
    issue(OP_FIND, 32'hF, draw_gap());
    issue(OP_INSERT, 32'h100, draw_gap());
    issue(OP_INSERT, 32'h1F0, draw_gap());
    issue(OP_TAKE, 32'h101, draw_gap());
    issue(OP_REMOVE, 32'h10F, draw_gap());
    start_i <= 1'b0;
    wait_idle();

    // single-level pool at the top
    write_reg(REG_MIN_LEVEL, 5'd31);
    write_reg(REG_MAX_LEVEL, 5'd31);
    issue(OP_INSERT, 32'h8000_0000, draw_gap());
    issue(OP_FIND, 32'h7FFF_FFFF, draw_gap());
    issue(OP_TAKE, 32'h8000_0000, draw_gap());
    start_i <= 1'b0;
    wait_idle();

    // inverted registers, plus writes to indexes with no register
    write_reg(REG_SPARE_LO, CFG_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_W'($urandom));
    write_reg(REG_MIN_LEVEL, 5'd31);
    write_reg(REG_MAX_LEVEL, 5'd4);
    issue(OP_INSERT, 32'h10, draw_gap());
    issue(OP_FIND, 32'h8000_0000, draw_gap());
    start_i <= 1'b0;
    wait_idle();
  endtask

  // Random requests, most aimed at a handful of lists so counts build up
  task automatic random_phase(int unsigned count);
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       r;
    int unsigned       lvl;
    int unsigned       pick;
    op_e               op;
    logic [SIZE_W-1:0] size;
    lo = tracker.min_lvl;
    hi = tracker.max_lvl;
    if (hi < lo) begin
      lo = LEVEL_FLOOR;
      hi = LEVEL_CEIL;
    end
    for (int h = 0; h < HOT_LISTS; h++) begin
      hot_lvl[h] = $urandom_range(lo, hi);
      hot_sub[h] = $urandom_range(0, SUB_DIM - 1);
    end
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) op = OP_INSERT;
      else if (r < 55) op = OP_REMOVE;
      else if (r < 75) op = OP_FIND;
      else op = OP_TAKE;

      r = $urandom_range(0, 99);
      if (r < 55) begin
        pick = $urandom_range(0, HOT_LISTS - 1);
        size = size_in_list(hot_lvl[pick], hot_sub[pick]);
      end else if (r < 80) begin
        // any list of the pool, one level either side included
        lvl  = $urandom_range((lo > LEVEL_FLOOR) ? lo - 1 : lo,
                              (hi < LEVEL_CEIL) ? hi + 1 : hi);
        size = size_in_list(lvl, $urandom_range(0, SUB_DIM - 1));
      end else if (r < 90) begin
        size = $urandom;
      end else begin
        lvl = $urandom_range(LEVEL_FLOOR, LEVEL_CEIL);
        case ($urandom_range(0, 4))
          0: size = 32'h10;
          1: size = 32'hFFFF_FFFF;
          2: size = 32'd1 << lvl;
          3: size = SIZE_W'((33'd1 << (lvl + 1)) - 33'd1);
          default: size = $urandom_range(0, 15);
        endcase
      end
      issue(op, size, draw_gap());
    end
    start_i <= 1'b0;
  endtask

  initial begin
    int unsigned lo;
    int unsigned hi;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_MIN_LEVEL;
    cfg_data_i   = '0;
    start_i      = 1'b0;
    operation_i  = OP_INSERT;
    chunk_size_i = '0;
    burst_left   = 0;
    tracker      = new();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // random phases over a spread of register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lo = 4;  hi = 31; end
        1: begin lo = 4;  hi = 4;  end
        2: begin lo = 31; hi = 31; end
        3: begin lo = 20; hi = 12; end
        4: begin lo = 10; hi = 24; end
        5: begin lo = 4;  hi = 31; end
        default: begin
          lo = $urandom_range(LEVEL_FLOOR, LEVEL_CEIL);
          hi = $urandom_range(LEVEL_FLOOR, LEVEL_CEIL);
        end
      endcase
      wait_idle();
      if (p == 3) write_reg(REG_SPARE_LO, CFG_W'($urandom));
      write_reg(REG_MIN_LEVEL, CFG_W'(lo));
      write_reg(REG_MAX_LEVEL, CFG_W'(hi));
      random_phase(ITEMS_PER_PHASE);
    end

    // short insert/remove/take sequence on one list with the reset registers
    wait_idle();
    write_reg(REG_MIN_LEVEL, MIN_LEVEL_RESET);
    write_reg(REG_MAX_LEVEL, MAX_LEVEL_RESET);
    issue(OP_REMOVE, FILL_SIZE, draw_gap());
    issue(OP_INSERT, FILL_SIZE, draw_gap());
    issue(OP_INSERT, FILL_SIZE, draw_gap());
    issue(OP_TAKE, FILL_SIZE, draw_gap());
    start_i <= 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("[tlsf_free_list_index_engine_top] OK");
    end else begin
      $display("[tlsf_free_list_index_engine_top] ERROR");
    end
    $finish;
  end

endmodule
